FILE: sv/nqse_pkg.sv
// Package for the n-queens solution enumerator: control word layout, condition
// and operation codes, field widths and the microcode ROM.
// Depends on nothing; the sequencer, datapath and top level import it.
package nqse_pkg;

   // Widths fixed by the external interface
   localparam int SIZE_W    = 4;
   localparam int COL_BITS  = 3;
   localparam int PACK_ROWS = 8;
   localparam int COLS_W    = COL_BITS * PACK_ROWS;
   localparam int INDEX_W   = 7;

   localparam logic [SIZE_W-1:0] BOARD_SIZE_RESET = 4'd8;

   // Microprogram step addresses
   typedef logic [3:0] step_type;

   localparam step_type S_IDLE       = 4'd0;
   localparam step_type S_DISPATCH   = 4'd1;
   localparam step_type S_CHECK_EXH  = 4'd2;
   localparam step_type S_RESUME     = 4'd3;
   localparam step_type S_START      = 4'd4;
   localparam step_type S_COL_TEST   = 4'd5;
   localparam step_type S_CHK_READ   = 4'd6;
   localparam step_type S_CHK_CMP    = 4'd7;
   localparam step_type S_NEXT_COL   = 4'd8;
   localparam step_type S_BACK       = 4'd9;
   localparam step_type S_BACK_READ  = 4'd10;
   localparam step_type S_BACK_LOAD  = 4'd11;
   localparam step_type S_PLACE      = 4'd12;
   localparam step_type S_EMIT_FOUND = 4'd13;
   localparam step_type S_EXHAUST    = 4'd14;
   localparam step_type S_EMIT_NONE  = 4'd15;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_ROW_LAST,
      OP_CHK_CLR,
      OP_CHK_INC,
      OP_COL_INC,
      OP_ROW_DEC,
      OP_COL_LOAD,
      OP_PLACE,
      OP_EMIT_FOUND,
      OP_EXHAUST,
      OP_EMIT_NONE
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_ACCEPT,
      C_START,
      C_EXHAUSTED,
      C_COL_END,
      C_CHK_DONE,
      C_NO_CONFLICT,
      C_ROW_ZERO,
      C_NOT_LAST
   } cond_type;

   typedef enum logic {
      RA_CHK,
      RA_ROW
   } raddr_type;

   // One microcode word
   typedef struct packed {
      op_type    op;
      cond_type  cond;
      step_type  target;
      raddr_type raddr;
      logic      wait_out;
   } cw_type;

   // Sequencer to datapath
   typedef struct packed {
      op_type    op;
      raddr_type raddr;
      logic      go;
      logic      idle;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic accept;
      logic start_req;
      logic exhausted;
      logic col_end;
      logic chk_done;
      logic no_conflict;
      logic row_zero;
      logic last_row;
      logic out_busy;
   } flags_type;

   function automatic cw_type mk_cw(op_type op, cond_type cond, step_type target,
                                    raddr_type raddr, logic wait_out);
      cw_type w;
      w.op       = op;
      w.cond     = cond;
      w.target   = target;
      w.raddr    = raddr;
      w.wait_out = wait_out;
      return w;
   endfunction

   // The search program. A taken condition jumps to target, otherwise fall through.
   function automatic cw_type ucode_rom(step_type pc);
      cw_type w;
      unique case (pc)
         S_IDLE:       w = mk_cw(OP_NONE,       C_NO_ACCEPT,   S_IDLE,      RA_CHK, 1'b0);
         S_DISPATCH:   w = mk_cw(OP_NONE,       C_START,       S_START,     RA_CHK, 1'b0);
         S_CHECK_EXH:  w = mk_cw(OP_NONE,       C_EXHAUSTED,   S_EMIT_NONE, RA_CHK, 1'b0);
         S_RESUME:     w = mk_cw(OP_ROW_LAST,   C_ALWAYS,      S_BACK_READ, RA_CHK, 1'b0);
         S_START:      w = mk_cw(OP_INIT,       C_NEVER,       S_IDLE,      RA_CHK, 1'b0);
         S_COL_TEST:   w = mk_cw(OP_CHK_CLR,    C_COL_END,     S_BACK,      RA_CHK, 1'b0);
         S_CHK_READ:   w = mk_cw(OP_NONE,       C_CHK_DONE,    S_PLACE,     RA_CHK, 1'b0);
         S_CHK_CMP:    w = mk_cw(OP_CHK_INC,    C_NO_CONFLICT, S_CHK_READ,  RA_CHK, 1'b0);
         S_NEXT_COL:   w = mk_cw(OP_COL_INC,    C_ALWAYS,      S_COL_TEST,  RA_CHK, 1'b0);
         S_BACK:       w = mk_cw(OP_ROW_DEC,    C_ROW_ZERO,    S_EXHAUST,   RA_CHK, 1'b0);
         S_BACK_READ:  w = mk_cw(OP_NONE,       C_NEVER,       S_IDLE,      RA_ROW, 1'b0);
         S_BACK_LOAD:  w = mk_cw(OP_COL_LOAD,   C_ALWAYS,      S_COL_TEST,  RA_CHK, 1'b0);
         S_PLACE:      w = mk_cw(OP_PLACE,      C_NOT_LAST,    S_COL_TEST,  RA_CHK, 1'b0);
         S_EMIT_FOUND: w = mk_cw(OP_EMIT_FOUND, C_ALWAYS,      S_IDLE,      RA_CHK, 1'b1);
         S_EXHAUST:    w = mk_cw(OP_EXHAUST,    C_NEVER,       S_IDLE,      RA_CHK, 1'b0);
         S_EMIT_NONE:  w = mk_cw(OP_EMIT_NONE,  C_ALWAYS,      S_IDLE,      RA_CHK, 1'b1);
         default:      w = mk_cw(OP_NONE,       C_ALWAYS,      S_IDLE,      RA_CHK, 1'b0);
      endcase
      return w;
   endfunction

endpackage

FILE: sv/nqse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nqse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/nqse_sequencer.sv
// Microcode sequencer: step counter, program ROM lookup and jump conditions.
// Depends on nqse_pkg (control word, codes, ucode_rom).
module nqse_sequencer
   import nqse_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   step_type pc_ff, pc_in;
   cw_type   cw;
   logic     taken;
   logic     go;

   assign cw = ucode_rom(pc_ff);

   always_comb begin
      unique case (cw.cond)
         C_NEVER:       taken = 1'b0;
         C_ALWAYS:      taken = 1'b1;
         C_NO_ACCEPT:   taken = !flags.accept;
         C_START:       taken = flags.start_req;
         C_EXHAUSTED:   taken = flags.exhausted;
         C_COL_END:     taken = flags.col_end;
         C_CHK_DONE:    taken = flags.chk_done;
         C_NO_CONFLICT: taken = flags.no_conflict;
         C_ROW_ZERO:    taken = flags.row_zero;
         C_NOT_LAST:    taken = !flags.last_row;
         default:       taken = 1'b0;
      endcase
   end

   // hold the emit steps while the result register is still full
   assign go = !(cw.wait_out && flags.out_busy);

   always_comb begin
      if (!go) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = cw.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op    = cw.op;
   assign ctrl.raddr = cw.raddr;
   assign ctrl.go    = go;
   assign ctrl.idle  = (pc_ff == S_IDLE);

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      flags.accept |=> (pc_ff == S_DISPATCH))
      else $error("accepted request did not move to dispatch");

   a_emit_only_stalls: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_EMIT_FOUND || pc_ff == S_EMIT_NONE) && !go |=> pc_ff == $past(pc_ff))
      else $error("emit step left while result register busy");

   a_idle_waits: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_IDLE) && !flags.accept |=> (pc_ff == S_IDLE))
      else $error("sequencer left idle without a request");

endmodule

FILE: sv/nqse_datapath.sv
// Datapath of the enumerator: search registers, placed-column RAM, safety
// compare, result packing and the result register. Depends on nqse_pkg, nqse_ram.
module nqse_datapath
   import nqse_pkg::*;
#(
   parameter int MAX_N = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_type           ctrl,
   output flags_type          flags,
   input  logic               req_fire,
   input  logic               req_restart,
   input  logic               csr_valid,
   input  logic [SIZE_W-1:0]  csr_board_size,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic               rsp_found,
   output logic [COLS_W-1:0]  rsp_queen_columns,
   output logic [INDEX_W-1:0] rsp_solution_index
);

   localparam int RW = $clog2(MAX_N + 1);
   localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int XW = RW + 1;

   logic [SIZE_W-1:0]  board_size_ff;
   logic [RW-1:0]      size_ff, eff_size;
   logic [RW-1:0]      row_ff, col_ff, chk_ff;
   logic               restart_ff, active_ff, exhausted_ff;
   logic [INDEX_W-1:0] count_ff;
   logic [COLS_W-1:0]  packed_ff;
   logic               rsp_valid_ff, rsp_found_ff;
   logic [COLS_W-1:0]  rsp_cols_ff;
   logic [INDEX_W-1:0] rsp_index_ff;

   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      rd_col;
   logic               wr_en;
   logic [XW-1:0]      c_x, col_x, dist_x;
   logic               emit;

   // clamp the written size into 1..MAX_N
   always_comb begin
      if (board_size_ff == '0) begin
         eff_size = RW'(1);
      end else if (int'(board_size_ff) > MAX_N) begin
         eff_size = RW'(MAX_N);
      end else begin
         eff_size = RW'(board_size_ff);
      end
   end

   assign wr_en   = ctrl.go && (ctrl.op == OP_PLACE);
   assign rd_addr = (ctrl.raddr == RA_ROW) ? row_ff[AW-1:0] : chk_ff[AW-1:0];

   nqse_ram #(
      .WIDTH (AW),
      .DEPTH (MAX_N)
   ) u_cols (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_ff[AW-1:0]),
      .wr_data (col_ff[AW-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_col)
   );

   // column, and both diagonals, of the queen in row chk against the candidate
   assign c_x    = XW'(rd_col);
   assign col_x  = XW'(col_ff);
   assign dist_x = XW'(row_ff - chk_ff);

   assign flags.accept      = req_fire;
   assign flags.start_req   = restart_ff || (!active_ff && !exhausted_ff);
   assign flags.exhausted   = exhausted_ff;
   assign flags.col_end     = (col_ff >= size_ff);
   assign flags.chk_done    = (chk_ff == row_ff);
   assign flags.no_conflict = (c_x != col_x) && (c_x + dist_x != col_x)
                              && (col_x + dist_x != c_x);
   assign flags.row_zero    = (row_ff == '0);
   assign flags.last_row    = (row_ff == size_ff - RW'(1));
   assign flags.out_busy    = rsp_valid_ff && rsp_stall;

   assign emit = ctrl.go && (ctrl.op == OP_EMIT_FOUND || ctrl.op == OP_EMIT_NONE);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff <= BOARD_SIZE_RESET;
         size_ff       <= RW'(1);
         restart_ff    <= 1'b0;
         active_ff     <= 1'b0;
         exhausted_ff  <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            board_size_ff <= csr_board_size;
         end
         if (req_fire) begin
            restart_ff <= req_restart;
         end
         if (ctrl.go) begin
            case (ctrl.op)
               OP_INIT: begin
                  size_ff      <= eff_size;
                  count_ff     <= '0;
                  active_ff    <= 1'b1;
                  exhausted_ff <= 1'b0;
               end
               OP_EXHAUST: begin
                  active_ff    <= 1'b0;
                  exhausted_ff <= 1'b1;
               end
               OP_EMIT_FOUND: count_ff <= count_ff + INDEX_W'(1);
               default: ;
            endcase
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // search registers and result payload
   always_ff @(posedge clock) begin
      if (ctrl.go) begin
         case (ctrl.op)
            OP_INIT: begin
               row_ff    <= '0;
               col_ff    <= '0;
               packed_ff <= '0;
            end
            OP_ROW_LAST: row_ff <= size_ff - RW'(1);
            OP_CHK_CLR:  chk_ff <= '0;
            OP_CHK_INC:  chk_ff <= chk_ff + RW'(1);
            OP_COL_INC:  col_ff <= col_ff + RW'(1);
            OP_ROW_DEC:  row_ff <= row_ff - RW'(1);
            OP_COL_LOAD: col_ff <= RW'(rd_col) + RW'(1);
            OP_PLACE: begin
               row_ff <= row_ff + RW'(1);
               col_ff <= '0;
               for (int i = 0; i < PACK_ROWS; i++) begin
                  if (i < MAX_N && int'(row_ff) == i) begin
                     packed_ff[COL_BITS*i +: COL_BITS] <= COL_BITS'(col_ff);
                  end
               end
            end
            default: ;
         endcase
      end
      if (emit) begin
         rsp_found_ff <= (ctrl.op == OP_EMIT_FOUND);
         rsp_cols_ff  <= (ctrl.op == OP_EMIT_FOUND) ? packed_ff : '0;
         rsp_index_ff <= count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_queen_columns  = rsp_cols_ff;
   assign rsp_solution_index = rsp_index_ff;

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      (size_ff >= RW'(1)) && (int'(size_ff) <= MAX_N))
      else $error("latched board size out of range");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(active_ff && exhausted_ff))
      else $error("search both active and exhausted");

   a_check_below_row: assert property (@(posedge clock) disable iff (reset)
      ctrl.go && ctrl.op == OP_CHK_INC |-> chk_ff < row_ff)
      else $error("safety check reached the current row");

endmodule

FILE: sv/n_queens_solution_enumerator.sv
// Top level of the n-queens solution enumerator.
// Depends on nqse_pkg, nqse_sequencer, nqse_datapath (which holds nqse_ram).
//
// csr_ channel: write board_size (n, 1..MAX_N; 0 acts as 1, larger acts as
//   MAX_N). Ready outside reset. Write it only while no request is in flight;
//   the value is sampled when a search starts. Reset value is 8.
// req_ channel: req_restart = 1 starts the search over, 0 asks for the next
//   solution (the first request after reset starts one).
// rsp_ channel: one result per request: rsp_found, the packed columns of rows
//   0..7 (3 bits per row) and the solution ordinal mod 128. After the last
//   solution every further request answers found = 0.
// Handshake: one request in flight; req_stall is low only in the idle step.
//   A square tried in row r is checked against each queen in rows 0..r-1 in
//   turn, since the RAM has a single read port (one read per queen above); a
//   conflict drops the square as soon as it is found.
// Stall and reset: the result waits in an output register while the next
//   request is taken; the sequencer holds at its emit step until that register
//   frees. Synchronous reset returns to idle with no search; no clearing pass.
module n_queens_solution_enumerator
   import nqse_pkg::*;
#(
   parameter int MAX_N = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SIZE_W-1:0]  csr_board_size,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [COLS_W-1:0]  rsp_queen_columns,
   output logic [INDEX_W-1:0] rsp_solution_index
);

   ctrl_type  ctrl;
   flags_type flags;
   logic      req_fire;

   // take a request only in the idle step, never during reset
   assign req_stall = reset || !ctrl.idle;
   assign req_fire  = req_valid && !req_stall;

   // size register takes a write at any time outside reset
   assign csr_ready = !reset;

   nqse_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   nqse_datapath #(
      .MAX_N (MAX_N)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .flags              (flags),
      .req_fire           (req_fire),
      .req_restart        (req_restart),
      .csr_valid          (csr_valid),
      .csr_board_size     (csr_board_size),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_found          (rsp_found),
      .rsp_queen_columns  (rsp_queen_columns),
      .rsp_solution_index (rsp_solution_index)
   );

endmodule
